### rtl/core/bole_pkg.sv
// package for the bounded ordered list engine
// sizes, codes, request/result structs and the cell command struct
// no dependencies
`timescale 1ns / 1ps

package bole_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GRP_SIZE   = 8;
  localparam int GRP_IDX_W  = $clog2(GRP_SIZE);
  localparam int NGRP       = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int OUT_CNT_W  = 7;
  localparam int OUT_IDX_W  = 6;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_FIND       = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC1,
    S_ENC2,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INS,
    MODE_DEL
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [OUT_IDX_W-1:0] found_index;
  } out_rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     cmp;
    cell_mode_t               mode;
    logic [IDX_W-1:0]         pos;
    logic signed [ELEM_W-1:0] key;
    logic [CNT_W-1:0]         count;
  } cell_cmd_t;

endpackage

### rtl/core/bounded_ordered_list_engine_top.sv
// a push, pop or no-op request goes to the apply state, and out_valid is registered
// from it; sorted insert and find go through compare, two encode stages, then apply
// a new request is accepted only while idle; busy is high in every other state
// sync active-low reset empties the list and clears the result strobe;
// element storage is not cleared. the receiver cannot stall results
`timescale 1ns / 1ps

module bounded_ordered_list_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bole_pkg::in_req_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output bole_pkg::out_rsp_t  out_data
);

  bole_pkg::state_t                  state_r;
  bole_pkg::state_t                  state_nxt;
  logic [2:0]                        act_r;
  logic signed [bole_pkg::ELEM_W-1:0] key_r;
  logic [bole_pkg::CNT_W-1:0]        count_r;
  logic [bole_pkg::CNT_W-1:0]        count_nxt;
  logic                              out_valid_r;
  bole_pkg::out_rsp_t                out_data_r;
  bole_pkg::out_rsp_t                rsp_nxt;
  bole_pkg::cell_cmd_t               cmd;
  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              needs_search;

  logic signed [bole_pkg::ELEM_W-1:0] cell_val [bole_pkg::CAPACITY];
  logic [bole_pkg::CAPACITY-1:0]     ge_vec;
  logic [bole_pkg::CAPACITY-1:0]     eq_vec;
  logic [bole_pkg::CAPACITY-1:0]     hit_vec;
  logic                              enc_hit;
  logic [bole_pkg::IDX_W-1:0]        enc_idx;

  assign accept = start && (state_r == bole_pkg::S_IDLE);
  assign full   = count_r == bole_pkg::CNT_W'(bole_pkg::CAPACITY);
  assign empty  = count_r == '0;
  assign needs_search = (in_data.action == bole_pkg::ACT_INSERT) ||
                        (in_data.action == bole_pkg::ACT_FIND);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bole_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = needs_search ? bole_pkg::S_CMP : bole_pkg::S_APPLY;
        end
      end
      bole_pkg::S_CMP:   state_nxt = bole_pkg::S_ENC1;
      bole_pkg::S_ENC1:  state_nxt = bole_pkg::S_ENC2;
      bole_pkg::S_ENC2:  state_nxt = bole_pkg::S_APPLY;
      bole_pkg::S_APPLY: state_nxt = bole_pkg::S_IDLE;
      default:           state_nxt = bole_pkg::S_IDLE;
    endcase
  end

  // outputs: cell command and the result of the request
  always_comb begin
    cmd.cmp   = (state_r == bole_pkg::S_CMP);
    cmd.mode  = bole_pkg::MODE_HOLD;
    cmd.pos   = '0;
    cmd.key   = key_r;
    cmd.count = count_r;
    count_nxt = count_r;
    rsp_nxt.status      = bole_pkg::STAT_OK;
    rsp_nxt.found_index = '0;
    if (state_r == bole_pkg::S_APPLY) begin
      unique case (act_r)
        bole_pkg::ACT_PUSH_BACK, bole_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            rsp_nxt.status = bole_pkg::STAT_FULL;
          end else begin
            cmd.mode  = bole_pkg::MODE_INS;
            cmd.pos   = (act_r == bole_pkg::ACT_PUSH_BACK) ?
                        bole_pkg::IDX_W'(count_r) : '0;
            count_nxt = count_r + 1'b1;
          end
        end
        bole_pkg::ACT_POP_BACK: begin
          if (empty) begin
            rsp_nxt.status = bole_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        bole_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            rsp_nxt.status = bole_pkg::STAT_EMPTY;
          end else begin
            cmd.mode  = bole_pkg::MODE_DEL;
            count_nxt = count_r - 1'b1;
          end
        end
        bole_pkg::ACT_INSERT: begin
          if (empty) begin
            rsp_nxt.status = bole_pkg::STAT_EMPTY;
          end else if (full) begin
            rsp_nxt.status = bole_pkg::STAT_FULL;
          end else begin
            // no entry at or above the key: append at the back
            cmd.mode  = bole_pkg::MODE_INS;
            cmd.pos   = enc_hit ? enc_idx : bole_pkg::IDX_W'(count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        bole_pkg::ACT_FIND: begin
          if (enc_hit) begin
            rsp_nxt.found_index = bole_pkg::OUT_IDX_W'(enc_idx);
          end else begin
            rsp_nxt.status = bole_pkg::STAT_NOTFOUND;
          end
        end
        default: begin
          rsp_nxt.status = bole_pkg::STAT_OK;
        end
      endcase
    end
    rsp_nxt.entry_count = bole_pkg::OUT_CNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == bole_pkg::S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_data.action;
      key_r <= bole_pkg::ELEM_W'(in_data.value);
    end
    if (state_r == bole_pkg::S_APPLY) begin
      out_data_r <= rsp_nxt;
    end
  end

  // chain of cells, front at position 0
  for (genvar i = 0; i < bole_pkg::CAPACITY; i++) begin : g_cell
    logic signed [bole_pkg::ELEM_W-1:0] left_v;
    logic signed [bole_pkg::ELEM_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = key_r;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == bole_pkg::CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    bole_cell u_cell (
      .clk      (clk),
      .cell_idx (bole_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .left_val (left_v),
      .right_val(right_v),
      .val      (cell_val[i]),
      .ge       (ge_vec[i]),
      .eq       (eq_vec[i])
    );
  end

  assign hit_vec = (act_r == bole_pkg::ACT_FIND) ? eq_vec : ge_vec;

  bole_enc u_enc (
    .clk    (clk),
    .hit_vec(hit_vec),
    .hit    (enc_hit),
    .idx    (enc_idx)
  );

  assign busy      = (state_r != bole_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/bole_cell.sv
// one list position: holds an element, compares it against the key and
// shifts toward either neighbor on insert or delete; uses bole_pkg
`timescale 1ns / 1ps

module bole_cell (
  input  logic                              clk,
  input  logic [bole_pkg::IDX_W-1:0]        cell_idx,
  input  bole_pkg::cell_cmd_t               cmd,
  input  logic signed [bole_pkg::ELEM_W-1:0] left_val,
  input  logic signed [bole_pkg::ELEM_W-1:0] right_val,
  output logic signed [bole_pkg::ELEM_W-1:0] val,
  output logic                              ge,
  output logic                              eq
);

  logic signed [bole_pkg::ELEM_W-1:0] val_r;
  logic signed [bole_pkg::ELEM_W-1:0] val_nxt;
  logic                               ge_r;
  logic                               eq_r;
  logic                               valid;

  assign valid = {1'b0, cell_idx} < cmd.count;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.mode)
      bole_pkg::MODE_INS: begin
        if (cell_idx == cmd.pos) begin
          val_nxt = cmd.key;
        end else if (cell_idx > cmd.pos) begin
          val_nxt = left_val;
        end
      end
      bole_pkg::MODE_DEL: begin
        if (cell_idx >= cmd.pos) begin
          val_nxt = right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (cmd.cmp) begin
      ge_r <= valid && !(val_r < cmd.key);
      eq_r <= valid && (val_r == cmd.key);
    end
  end

  assign val = val_r;
  assign ge  = ge_r;
  assign eq  = eq_r;

endmodule

### rtl/core/bole_enc.sv
// two-stage registered first-hit encoder over the cell flags
// groups of eight, then a pick over the groups; uses bole_pkg
`timescale 1ns / 1ps

module bole_enc (
  input  logic                          clk,
  input  logic [bole_pkg::CAPACITY-1:0] hit_vec,
  output logic                          hit,
  output logic [bole_pkg::IDX_W-1:0]    idx
);

  localparam int PAD_W = bole_pkg::NGRP * bole_pkg::GRP_SIZE;

  logic [PAD_W-1:0]                  padded;
  logic [bole_pkg::NGRP-1:0]         grp_hit_nxt;
  logic [bole_pkg::GRP_IDX_W-1:0]    grp_pos_nxt [bole_pkg::NGRP];
  logic [bole_pkg::NGRP-1:0]         grp_hit_r;
  logic [bole_pkg::GRP_IDX_W-1:0]    grp_pos_r [bole_pkg::NGRP];
  logic                              hit_nxt;
  logic [bole_pkg::IDX_W-1:0]        idx_nxt;
  logic                              hit_r;
  logic [bole_pkg::IDX_W-1:0]        idx_r;

  assign padded = PAD_W'(hit_vec);

  // first set bit inside each group
  always_comb begin
    for (int g = 0; g < bole_pkg::NGRP; g++) begin
      grp_hit_nxt[g] = |padded[g*bole_pkg::GRP_SIZE +: bole_pkg::GRP_SIZE];
      grp_pos_nxt[g] = '0;
      for (int b = bole_pkg::GRP_SIZE - 1; b >= 0; b--) begin
        if (padded[g*bole_pkg::GRP_SIZE + b]) begin
          grp_pos_nxt[g] = bole_pkg::GRP_IDX_W'(b);
        end
      end
    end
  end

  // first group that holds a hit
  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    for (int g = bole_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        hit_nxt = 1'b1;
        idx_nxt = bole_pkg::IDX_W'(g * bole_pkg::GRP_SIZE + int'(grp_pos_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_pos_r <= grp_pos_nxt;
    hit_r     <= hit_nxt;
    idx_r     <= idx_nxt;
  end

  assign hit = hit_r;
  assign idx = idx_r;

endmodule
